FILE: sv/tmg_pkg.sv
// Shared types, constants and helpers for the transform matrix generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package tmg_pkg;

  localparam int FracBitsDef     = 16;
  localparam int CordicStagesDef = 16;
  localparam int CordicMax       = 24;
  localparam int WorkFrac        = 30;

  localparam logic [3:0] FN_TRANSLATE = 4'd0;
  localparam logic [3:0] FN_SCALE     = 4'd1;
  localparam logic [3:0] FN_AXIS_ROT  = 4'd2;
  localparam logic [3:0] FN_ROT_X     = 4'd3;
  localparam logic [3:0] FN_ROT_Y     = 4'd4;
  localparam logic [3:0] FN_ROT_Z     = 4'd5;
  localparam logic [3:0] FN_MIRROR_X  = 4'd6;
  localparam logic [3:0] FN_MIRROR_Y  = 4'd7;
  localparam logic [3:0] FN_MIRROR_Z  = 4'd8;

  localparam logic signed [31:0] GainQ30 = 32'sd652032874;

  localparam logic signed [31:0] AtanTurn [CordicMax] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331, 32'sd21354465, 32'sd10679838, 32'sd5340245,
    32'sd2670163, 32'sd1335087, 32'sd667544, 32'sd333772,
    32'sd166886, 32'sd83443, 32'sd41722, 32'sd20861,
    32'sd10430, 32'sd5215, 32'sd2608, 32'sd1304,
    32'sd652, 32'sd326, 32'sd163, 32'sd81
  };

  typedef struct packed {
    logic [3:0]         func;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } req_t;

  // row-major matrix, element k = row*4 + col, element 0 in the lowest bits
  typedef logic [15:0][31:0] mat_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] res;
    if (v > 66'sd2147483647) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < -66'sd2147483648) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

FILE: sv/tmg_cordic.sv
// Pipelined CORDIC: one rotation per register stage, sine and cosine out.
// Depends on tmg_pkg; carries the request alongside the angle.
`default_nettype none
module tmg_cordic #(
  parameter int FRAC_BITS     = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire tmg_pkg::req_t      in_req,
  input  wire logic [15:0]        in_angle,
  output logic                    out_valid,
  output tmg_pkg::req_t           out_req,
  output logic signed [31:0]      out_sin,
  output logic signed [31:0]      out_cos
);
  import tmg_pkg::*;

  localparam int Sh = WorkFrac - FRAC_BITS;
  localparam int N  = CORDIC_STAGES;

  logic               v_r    [N+1];
  logic               flip_r [N+1];
  req_t               req_r  [N+1];
  logic signed [33:0] x_r    [N+1];
  logic signed [33:0] y_r    [N+1];
  logic signed [31:0] z_r    [N+1];

  logic [31:0] ang_w;
  logic [31:0] ang_q;
  logic        flip_w;

  assign ang_w  = {in_angle, 16'h0000};
  assign ang_q  = ang_w + 32'h4000_0000;
  assign flip_w = ang_q[31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  // fold the left half-plane onto the right, negate at the end
  always_ff @(posedge clk) begin
    if (en) begin
      flip_r[0] <= flip_w;
      req_r[0]  <= in_req;
      x_r[0]    <= 34'(GainQ30);
      y_r[0]    <= '0;
      z_r[0]    <= flip_w ? $signed(ang_w + 32'h8000_0000) : $signed(ang_w);
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] xs_w;
    logic signed [33:0] ys_w;
    assign xs_w = x_r[i] >>> i;
    assign ys_w = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (en) begin
        v_r[i+1] <= v_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        req_r[i+1]  <= req_r[i];
        if (z_r[i] >= 0) begin
          x_r[i+1] <= x_r[i] - ys_w;
          y_r[i+1] <= y_r[i] + xs_w;
          z_r[i+1] <= z_r[i] - AtanTurn[i];
        end else begin
          x_r[i+1] <= x_r[i] + ys_w;
          y_r[i+1] <= y_r[i] - xs_w;
          z_r[i+1] <= z_r[i] + AtanTurn[i];
        end
      end
    end
  end

  logic signed [34:0] xf_w;
  logic signed [34:0] yf_w;
  logic signed [34:0] xr_w;
  logic signed [34:0] yr_w;

  assign xf_w = flip_r[N] ? -35'(x_r[N]) : 35'(x_r[N]);
  assign yf_w = flip_r[N] ? -35'(y_r[N]) : 35'(y_r[N]);
  assign xr_w = (xf_w + (35'sd1 <<< (Sh - 1))) >>> Sh;
  assign yr_w = (yf_w + (35'sd1 <<< (Sh - 1))) >>> Sh;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_r[N];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_req <= req_r[N];
      out_cos <= sat32(66'(xr_w));
      out_sin <= sat32(66'(yr_w));
    end
  end

endmodule
`default_nettype wire

FILE: sv/tmg_matrix.sv
// Five-stage product and sum pipeline that assembles the 4x4 matrix.
// Depends on tmg_pkg; fed by tmg_cordic with sine, cosine and the request.
`default_nettype none
module tmg_matrix #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire tmg_pkg::req_t      in_req,
  input  wire logic signed [31:0] in_sin,
  input  wire logic signed [31:0] in_cos,
  output logic                    out_valid,
  output tmg_pkg::mat_t           out_mat
);
  import tmg_pkg::*;

  localparam logic signed [31:0] One = 32'sd1 <<< FRAC_BITS;

  function automatic logic signed [31:0] fxr(input logic signed [63:0] p);
    logic signed [64:0] r;
    r = 65'(p) + (65'sd1 <<< (FRAC_BITS - 1));
    return sat32(66'(r >>> FRAC_BITS));
  endfunction

  function automatic logic signed [31:0] add32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) + 66'(b));
  endfunction

  function automatic logic signed [31:0] sub32(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    return sat32(66'(a) - 66'(b));
  endfunction

  logic               v_r  [1:5];
  req_t               req_r[1:4];
  logic signed [31:0] sn_r [1:4];
  logic signed [31:0] cs_r [1:4];
  logic signed [31:0] t_r  [1:2];
  logic signed [63:0] p1_r [9];
  logic signed [31:0] q2_r [9];
  logic signed [63:0] p3_r [6];
  logic signed [31:0] q3_r [6];
  logic signed [31:0] r4_r [6];
  logic signed [31:0] q4_r [6];
  mat_t               mat_r;
  mat_t               mat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 1; k <= 5; k++) v_r[k] <= 1'b0;
    end else if (en) begin
      v_r[1] <= in_valid;
      for (int k = 2; k <= 5; k++) v_r[k] <= v_r[k-1];
    end
  end

  // products: xx yy zz xy xz yz zs ys xs
  always_ff @(posedge clk) begin
    if (en) begin
      req_r[1] <= in_req;
      sn_r[1]  <= in_sin;
      cs_r[1]  <= in_cos;
      t_r[1]   <= sub32(One, in_cos);
      p1_r[0]  <= in_req.vx * in_req.vx;
      p1_r[1]  <= in_req.vy * in_req.vy;
      p1_r[2]  <= in_req.vz * in_req.vz;
      p1_r[3]  <= in_req.vx * in_req.vy;
      p1_r[4]  <= in_req.vx * in_req.vz;
      p1_r[5]  <= in_req.vy * in_req.vz;
      p1_r[6]  <= in_req.vz * in_sin;
      p1_r[7]  <= in_req.vy * in_sin;
      p1_r[8]  <= in_req.vx * in_sin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r[2] <= req_r[1];
      sn_r[2]  <= sn_r[1];
      cs_r[2]  <= cs_r[1];
      t_r[2]   <= t_r[1];
      for (int k = 0; k < 9; k++) q2_r[k] <= fxr(p1_r[k]);
    end
  end

  // second products: (1-dd)c on the diagonal, pair terms times t
  always_ff @(posedge clk) begin
    if (en) begin
      req_r[3] <= req_r[2];
      sn_r[3]  <= sn_r[2];
      cs_r[3]  <= cs_r[2];
      for (int k = 0; k < 3; k++) begin
        p3_r[k]   <= sub32(One, q2_r[k]) * cs_r[2];
        p3_r[k+3] <= q2_r[k+3] * t_r[2];
        q3_r[k]   <= q2_r[k];
        q3_r[k+3] <= q2_r[k+6];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      req_r[4] <= req_r[3];
      sn_r[4]  <= sn_r[3];
      cs_r[4]  <= cs_r[3];
      for (int k = 0; k < 6; k++) begin
        r4_r[k] <= fxr(p3_r[k]);
        q4_r[k] <= q3_r[k];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) mat_nxt[k] = (k % 5 == 0) ? One : 32'sd0;
    case (req_r[4].func)
      FN_TRANSLATE: begin
        mat_nxt[3]  = req_r[4].vx;
        mat_nxt[7]  = req_r[4].vy;
        mat_nxt[11] = req_r[4].vz;
      end
      FN_SCALE: begin
        mat_nxt[0]  = req_r[4].vx;
        mat_nxt[5]  = req_r[4].vy;
        mat_nxt[10] = req_r[4].vz;
      end
      FN_AXIS_ROT: begin
        mat_nxt[0]  = add32(q4_r[0], r4_r[0]);
        mat_nxt[5]  = add32(q4_r[1], r4_r[1]);
        mat_nxt[10] = add32(q4_r[2], r4_r[2]);
        mat_nxt[4]  = add32(r4_r[3], q4_r[3]);
        mat_nxt[1]  = sub32(r4_r[3], q4_r[3]);
        mat_nxt[8]  = sub32(r4_r[4], q4_r[4]);
        mat_nxt[2]  = add32(r4_r[4], q4_r[4]);
        mat_nxt[9]  = add32(r4_r[5], q4_r[5]);
        mat_nxt[6]  = sub32(r4_r[5], q4_r[5]);
      end
      FN_ROT_X: begin
        mat_nxt[5]  = cs_r[4];
        mat_nxt[6]  = sub32(32'sd0, sn_r[4]);
        mat_nxt[9]  = sn_r[4];
        mat_nxt[10] = cs_r[4];
      end
      FN_ROT_Y: begin
        mat_nxt[0]  = cs_r[4];
        mat_nxt[2]  = sub32(32'sd0, sn_r[4]);
        mat_nxt[8]  = sn_r[4];
        mat_nxt[10] = cs_r[4];
      end
      FN_ROT_Z: begin
        mat_nxt[0]  = cs_r[4];
        mat_nxt[1]  = sub32(32'sd0, sn_r[4]);
        mat_nxt[4]  = sn_r[4];
        mat_nxt[5]  = cs_r[4];
      end
      FN_MIRROR_X: mat_nxt[0]  = -One;
      FN_MIRROR_Y: mat_nxt[5]  = -One;
      FN_MIRROR_Z: mat_nxt[10] = -One;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mat_r <= mat_nxt;
    end
  end

  assign out_valid = v_r[5];
  assign out_mat   = mat_r;

endmodule
`default_nettype wire

FILE: sv/tmg_row_out.sv
// Holds one finished matrix and sends it out one row per item.
// Depends on tmg_pkg for the matrix type.
`default_nettype none
module tmg_row_out (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire tmg_pkg::mat_t in_mat,
  output logic               in_ready,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [127:0]       out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast
);
  import tmg_pkg::*;

  logic       busy_r;
  logic [1:0] row_r;
  mat_t       mat_r;
  logic       fire;
  logic       load;

  assign fire     = out_tvalid && out_tready;
  assign load     = !busy_r || (fire && row_r == 2'd3);
  assign in_ready = load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= 2'd0;
    end else if (load) begin
      busy_r <= in_valid;
      row_r  <= 2'd0;
    end else if (fire) begin
      row_r  <= row_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      mat_r <= in_mat;
    end
  end

  assign out_tvalid = busy_r;
  assign out_tdata  = mat_r[{row_r, 2'b00} +: 4];
  assign out_tuser  = row_r;
  assign out_tlast  = (row_r == 2'd3);

  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && row_r != 2'd3) |=> (out_tvalid && row_r == $past(row_r) + 2'd1))
    else $error("row did not advance after accepted item");

  a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
    (load && in_valid) |=> (busy_r && row_r == 2'd0))
    else $error("new matrix not started at row zero");

  a_idle_row: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> row_r == 2'd0)
    else $error("row counter moved while idle");

endmodule
`default_nettype wire

FILE: sv/transform_matrix_generator.sv
// Homogeneous 4x4 transform generator.
// Input channel in_*: one request per item (func in tuser, vectors and angle
// in tdata). Output channel out_*: four items per request, one matrix row
// each, row number in tuser, tlast on the fourth row.
// An accepted request passes the CORDIC stages, the matrix stages and the
// row buffer before its first row, then one row per cycle while out_tready
// is high. The single result channel carrying four rows limits the request
// rate; the CORDIC and product pipeline accept one request per cycle while
// not frozen and absorb bursts.
// Reset (rst_n low at a clock edge) empties every stage; nothing is sent
// until a new request arrives.
// When the receiver stalls, the row holds on out_tdata, the whole pipeline
// freezes once its last stage holds a matrix, and in_tready falls; nothing
// is lost or repeated.
// Depends on tmg_pkg, tmg_cordic, tmg_matrix and tmg_row_out.
`default_nettype none
module transform_matrix_generator #(
  parameter int FRAC_BITS     = tmg_pkg::FracBitsDef,
  parameter int CORDIC_STAGES = tmg_pkg::CordicStagesDef
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [111:0] in_tdata,  // vec_x, vec_y, vec_z, angle
  input  wire logic [3:0]   in_tuser,  // func
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [127:0]      out_tdata, // col0, col1, col2, col3
  output logic [1:0]        out_tuser, // row_index
  output logic              out_tlast  // last_row
);
  import tmg_pkg::*;

  logic               adv;
  req_t               req_w;
  logic               cv_w;
  req_t               creq_w;
  logic signed [31:0] sin_w;
  logic signed [31:0] cos_w;
  logic               mv_w;
  mat_t               mat_w;
  logic               ro_ready;

  assign req_w.func = in_tuser;
  assign req_w.vx   = in_tdata[31:0];
  assign req_w.vy   = in_tdata[63:32];
  assign req_w.vz   = in_tdata[95:64];

  // advance all stages together unless a finished matrix is waiting
  assign adv       = !mv_w || ro_ready;
  assign in_tready = adv;

  tmg_cordic #(
    .FRAC_BITS    (FRAC_BITS),
    .CORDIC_STAGES(CORDIC_STAGES)
  ) u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (in_tvalid),
    .in_req   (req_w),
    .in_angle (in_tdata[111:96]),
    .out_valid(cv_w),
    .out_req  (creq_w),
    .out_sin  (sin_w),
    .out_cos  (cos_w)
  );

  tmg_matrix #(
    .FRAC_BITS(FRAC_BITS)
  ) u_matrix (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_valid (cv_w),
    .in_req   (creq_w),
    .in_sin   (sin_w),
    .in_cos   (cos_w),
    .out_valid(mv_w),
    .out_mat  (mat_w)
  );

  tmg_row_out u_row_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mv_w),
    .in_mat    (mat_w),
    .in_ready  (ro_ready),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule
`default_nettype wire
